/* rtl/rsi_pkg.sv */
// Shared constants for the ray-sphere intersection pipeline.
// No dependencies; imported by the channel interfaces and the top level.
package rsi_pkg;

	localparam int R2_W      = 48;   // squared radius, unsigned Q16.32
	localparam int DIST_W    = 32;   // distance, unsigned Q16.16
	localparam int FRAC_BITS = 16;   // fraction bits of the distance
	localparam int Q_BITS    = 32;   // quotient bits produced by the divider

	localparam logic [DIST_W-1:0] DIST_SAT = '1;

endpackage

/* rtl/rsi_chan_if.sv */
// Valid/ready channels for ray-sphere requests and results.
// Depends on rsi_pkg for the radius and distance widths.
interface rsi_req_if import rsi_pkg::*; #(parameter int COORD_WIDTH = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] origin_x;
	logic signed [COORD_WIDTH-1:0] origin_y;
	logic signed [COORD_WIDTH-1:0] origin_z;
	logic signed [COORD_WIDTH-1:0] dir_x;
	logic signed [COORD_WIDTH-1:0] dir_y;
	logic signed [COORD_WIDTH-1:0] dir_z;
	logic signed [COORD_WIDTH-1:0] center_x;
	logic signed [COORD_WIDTH-1:0] center_y;
	logic signed [COORD_WIDTH-1:0] center_z;
	logic        [R2_W-1:0]        radius_sq;

	modport source (
		output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		       center_x, center_y, center_z, radius_sq,
		input  ready
	);
	modport sink (
		input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		       center_x, center_y, center_z, radius_sq,
		output ready
	);
endinterface

interface rsi_res_if import rsi_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              hit;
	logic              far_root;
	logic [DIST_W-1:0] distance;

	modport source (output valid, hit, far_root, distance, input ready);
	modport sink   (input valid, hit, far_root, distance, output ready);
endinterface

/* rtl/ray_sphere_intersection.sv */
// Ray-sphere intersection: one request per cycle while no result is stalled, fully pipelined.
// The pipeline depth depends on K_W = max(2*COORD_WIDTH+2, 48) + 1 (51 at 24 bits);
// the square root (one bit per stage) and the 32-stage divider set that depth.
// Throughput is one request per cycle; a stalled result freezes the whole pipe.
// Reset clears every stage valid bit asynchronously; data registers are not reset.
// Depends on rsi_pkg, rsi_chan_if, rsi_mul and rsi_sqrt.
module ray_sphere_intersection import rsi_pkg::*; #(
	parameter int COORD_WIDTH = 24
) (
	input  logic     clk,
	input  logic     arst_n,
	rsi_req_if.sink  req,
	rsi_res_if.source res
);
	localparam int W      = COORD_WIDTH;
	localparam int OC_W   = W + 1;               // o - c
	localparam int PR_W   = 2 * OC_W;            // any coordinate product
	localparam int SUM_W  = PR_W + 2;            // three products summed
	localparam int A_W    = 2 * W;               // a = d.d, unsigned
	localparam int H_W    = 2 * W + 2;           // h = d.oc, signed
	localparam int K_W    = ((2 * W + 2 > R2_W) ? 2 * W + 2 : R2_W) + 1;
	localparam int KS_W   = ((SUM_W > K_W) ? SUM_W : K_W) + 1;
	localparam int MUL_W  = K_W;                 // covers |h|, |k| and a
	localparam int DISC_W = 2 * MUL_W + 1;
	localparam int SQ_W   = MUL_W;
	localparam int NUM_W  = MUL_W + 2;
	localparam int R_W    = A_W + Q_BITS;        // divider remainder
	localparam int EXT_W  = NUM_W + R_W;
	localparam int TA_W   = A_W + H_W;
	localparam int TS_W   = A_W + H_W + 1;

	// Global advance: the pipe moves unless a finished result is being held.
	logic en;
	assign en        = !res.valid || res.ready;
	assign req.ready = en;

	// ---------------- stage 1: register the ray, form o - c ----------------
	logic signed [OC_W-1:0] d_s1  [3];
	logic signed [OC_W-1:0] oc_s1 [3];
	logic        [R2_W-1:0] r2_s1;
	logic                   v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0]  <= OC_W'(req.dir_x);
			d_s1[1]  <= OC_W'(req.dir_y);
			d_s1[2]  <= OC_W'(req.dir_z);
			oc_s1[0] <= OC_W'(req.origin_x) - OC_W'(req.center_x);
			oc_s1[1] <= OC_W'(req.origin_y) - OC_W'(req.center_y);
			oc_s1[2] <= OC_W'(req.origin_z) - OC_W'(req.center_z);
			r2_s1    <= req.radius_sq;
		end
	end

	// ---------------- stage 2: the nine coordinate products ----------------
	logic signed [PR_W-1:0] dd_s2 [3];
	logic signed [PR_W-1:0] do_s2 [3];
	logic signed [PR_W-1:0] oo_s2 [3];
	logic        [R2_W-1:0] r2_s2;
	logic                   v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= d_s1[i] * d_s1[i];
				do_s2[i] <= d_s1[i] * oc_s1[i];
				oo_s2[i] <= oc_s1[i] * oc_s1[i];
			end
			r2_s2 <= r2_s1;
		end
	end

	// ---------------- stage 3: a, h and k ----------------
	logic signed [SUM_W-1:0] a_sum, h_sum;
	logic signed [KS_W-1:0]  k_sum;
	logic        [A_W-1:0]   a_s3;
	logic signed [H_W-1:0]   h_s3;
	logic signed [K_W-1:0]   k_s3;
	logic                    v_s3;

	assign a_sum = SUM_W'(dd_s2[0]) + SUM_W'(dd_s2[1]) + SUM_W'(dd_s2[2]);
	assign h_sum = SUM_W'(do_s2[0]) + SUM_W'(do_s2[1]) + SUM_W'(do_s2[2]);
	assign k_sum = KS_W'(oo_s2[0]) + KS_W'(oo_s2[1]) + KS_W'(oo_s2[2])
	             - $signed({{(KS_W - R2_W){1'b0}}, r2_s2});

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= a_sum[A_W-1:0];
			h_s3 <= h_sum[H_W-1:0];
			k_s3 <= k_sum[K_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// ---------------- h*h and a*k on magnitudes, two stages ----------------
	logic signed [MUL_W-1:0] h_x, k_x;
	logic        [MUL_W-1:0] h_mag, k_mag;
	logic [2*MUL_W-1:0]      hh_m, ak_m;
	logic [TA_W-1:0]         tag_hh;
	logic [1:0]              tag_ak;
	logic                    v_hh, v_ak;

	assign h_x   = MUL_W'(h_s3);
	assign k_x   = MUL_W'(k_s3);
	assign h_mag = h_x[MUL_W-1] ? -h_x : h_x;
	assign k_mag = k_x[MUL_W-1] ? -k_x : k_x;

	rsi_mul #(.WIDTH(MUL_W), .TAG_W(TA_W)) u_mul_hh (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.a         (h_mag),
		.b         (h_mag),
		.tag_in    ({a_s3, h_s3}),
		.out_valid (v_hh),
		.p         (hh_m),
		.tag_out   (tag_hh)
	);

	rsi_mul #(.WIDTH(MUL_W), .TAG_W(2)) u_mul_ak (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.a         (MUL_W'(a_s3)),
		.b         (k_mag),
		.tag_in    ({k_s3[K_W-1], a_s3 == '0}),
		.out_valid (v_ak),
		.p         (ak_m),
		.tag_out   (tag_ak)
	);

	// ---------------- stage 4: discriminant / 4 = h*h - a*k ----------------
	logic signed [DISC_W-1:0] hh_x, ak_x, disc;
	logic                     disc_pos;
	logic [2*SQ_W-1:0]        rad_s4;
	logic [A_W-1:0]           a_s4;
	logic signed [H_W-1:0]    h_s4;
	logic                     miss_s4, v_s4;

	assign hh_x     = $signed({1'b0, hh_m});
	assign ak_x     = $signed({1'b0, ak_m});
	assign disc     = tag_ak[1] ? hh_x + ak_x : hh_x - ak_x;
	assign disc_pos = !disc[DISC_W-1] && (disc != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4  <= disc[2*SQ_W-1:0];
			a_s4    <= tag_hh[TA_W-1 -: A_W];
			h_s4    <= $signed(tag_hh[H_W-1:0]);
			// zero direction or a grazing / missing ray
			miss_s4 <= tag_ak[0] || !disc_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_hh;
		end
	end

	// ---------------- floor square root ----------------
	logic [SQ_W-1:0]       root;
	logic [TS_W-1:0]       tag_sq;
	logic                  v_sq;
	logic [A_W-1:0]        a_sq;
	logic signed [H_W-1:0] h_sq;
	logic                  miss_sq;

	rsi_sqrt #(.WIDTH(SQ_W), .TAG_W(TS_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.rad       (rad_s4),
		.tag_in    ({a_s4, h_s4, miss_s4}),
		.out_valid (v_sq),
		.root      (root),
		.tag_out   (tag_sq)
	);

	assign a_sq    = tag_sq[TS_W-1 -: A_W];
	assign h_sq    = $signed(tag_sq[H_W:1]);
	assign miss_sq = tag_sq[0];

	// ---------------- stage 5: pick the root ----------------
	logic signed [NUM_W-1:0] nh, s_x, num1, num2;
	logic                    pos1, pos2;
	logic [NUM_W-2:0]        num_s5;
	logic [A_W-1:0]          a_s5;
	logic                    hit_s5, far_s5, v_s5;

	assign nh   = -NUM_W'(h_sq);
	assign s_x  = $signed({2'b00, root});
	assign num1 = nh - s_x;
	assign num2 = nh + s_x;
	assign pos1 = !num1[NUM_W-1] && (num1 != '0);
	assign pos2 = !num2[NUM_W-1] && (num2 != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			// prefer the nearer root, fall back to the farther one
			num_s5 <= pos1 ? num1[NUM_W-2:0] : num2[NUM_W-2:0];
			a_s5   <= a_sq;
			hit_s5 <= !miss_sq && (pos1 || pos2);
			far_s5 <= !pos1;
		end
	end

	// ---------------- stage 6: saturation check, scale for the divider ----------------
	localparam int NST = Q_BITS + 1;

	logic [EXT_W-1:0] num_ext, lim;
	logic [R_W-1:0]   div_rem_s [NST];
	logic [Q_BITS-1:0] div_q_s  [NST];
	logic [A_W-1:0]   div_a_s   [NST];
	logic             div_hit_s [NST];
	logic             div_far_s [NST];
	logic             div_sat_s [NST];
	logic             div_v_s   [NST];

	assign num_ext = EXT_W'(num_s5);
	assign lim     = EXT_W'(a_s5) << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			div_rem_s[0] <= {num_ext[R_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
			div_q_s[0]   <= '0;
			div_a_s[0]   <= a_s5;
			div_hit_s[0] <= hit_s5;
			div_far_s[0] <= far_s5;
			div_sat_s[0] <= num_ext >= lim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5       <= 1'b0;
			div_v_s[0] <= 1'b0;
		end else if (en) begin
			v_s5       <= v_sq;
			div_v_s[0] <= v_s5;
		end
	end

	// ---------------- restoring divider, one quotient bit per stage ----------------
	for (genvar j = 0; j < Q_BITS; j++) begin : g_div
		localparam int SH = Q_BITS - 1 - j;
		logic [R_W-1:0] a_sh;
		logic           ge;

		assign a_sh = R_W'(div_a_s[j]) << SH;
		assign ge   = div_rem_s[j] >= a_sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[j+1] <= 1'b0;
			end else if (en) begin
				div_v_s[j+1] <= div_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[j+1] <= ge ? div_rem_s[j] - a_sh : div_rem_s[j];
				div_q_s[j+1]   <= {div_q_s[j][Q_BITS-2:0], ge};
				div_a_s[j+1]   <= div_a_s[j];
				div_hit_s[j+1] <= div_hit_s[j];
				div_far_s[j+1] <= div_far_s[j];
				div_sat_s[j+1] <= div_sat_s[j];
			end
		end
	end

	// ---------------- result ----------------
	// The last divider stage is the output register; a miss reports zeros.
	assign res.valid    = div_v_s[Q_BITS];
	assign res.hit      = div_hit_s[Q_BITS];
	assign res.far_root = div_hit_s[Q_BITS] && div_far_s[Q_BITS];
	assign res.distance = !div_hit_s[Q_BITS] ? '0 :
	                      div_sat_s[Q_BITS]  ? DIST_SAT : div_q_s[Q_BITS];

	// ---------------- assertions ----------------
	// both multiplier lanes must stay in lockstep
	a_mul_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		v_hh == v_ak)
		else $error("multiplier lanes out of step");

	// an accepted request always lands in stage 1
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> v_s1)
		else $error("accepted request dropped at entry");

	// a held result keeps its distance while the pipe is frozen
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res.distance)))
		else $error("stalled result changed");
endmodule

/* rtl/rsi_mul.sv */
// Two-stage unsigned multiplier built from four half-width partial products.
// No package dependencies; a side tag travels with each operand pair.
module rsi_mul #(
	parameter int WIDTH = 51,
	parameter int TAG_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [WIDTH-1:0]   a,
	input  logic [WIDTH-1:0]   b,
	input  logic [TAG_W-1:0]   tag_in,
	output logic               out_valid,
	output logic [2*WIDTH-1:0] p,
	output logic [TAG_W-1:0]   tag_out
);
	localparam int HALF = (WIDTH + 1) / 2;
	localparam int DW   = 2 * HALF;
	localparam int PW   = 4 * HALF;

	logic [DW-1:0]    ax, bx;
	logic [DW-1:0]    ll_s1, lh_s1, hl_s1, hh_s1;
	logic [TAG_W-1:0] tag_s1;
	logic             v_s1;
	logic [PW-1:0]    sum;

	assign ax = DW'(a);
	assign bx = DW'(b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	// partial products of the low and high halves
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= ax[HALF-1:0] * bx[HALF-1:0];
			lh_s1  <= ax[HALF-1:0] * bx[DW-1:HALF];
			hl_s1  <= ax[DW-1:HALF] * bx[HALF-1:0];
			hh_s1  <= ax[DW-1:HALF] * bx[DW-1:HALF];
			tag_s1 <= tag_in;
		end
	end

	assign sum = {hh_s1, ll_s1} + ((PW'(lh_s1) + PW'(hl_s1)) << HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			p       <= sum[2*WIDTH-1:0];
			tag_out <= tag_s1;
		end
	end
endmodule

/* rtl/rsi_sqrt.sv */
// Pipelined floor square root, one root bit resolved per stage.
// No package dependencies; a side tag travels with each radicand.
module rsi_sqrt #(
	parameter int WIDTH = 51,
	parameter int TAG_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [2*WIDTH-1:0] rad,
	input  logic [TAG_W-1:0]   tag_in,
	output logic               out_valid,
	output logic [WIDTH-1:0]   root,
	output logic [TAG_W-1:0]   tag_out
);
	logic [2*WIDTH-1:0] rad_s  [WIDTH];
	logic [WIDTH+1:0]   rem_s  [WIDTH];
	logic [WIDTH-1:0]   root_s [WIDTH];
	logic [TAG_W-1:0]   tag_s  [WIDTH];
	logic               v_s    [WIDTH];

	for (genvar i = 0; i < WIDTH; i++) begin : g_st
		logic [2*WIDTH-1:0] rad_i;
		logic [WIDTH+1:0]   rem_i, rem_sh, trial;
		logic [WIDTH-1:0]   root_i;
		logic [TAG_W-1:0]   tag_i;
		logic               v_i, ge;

		if (i == 0) begin : g_head
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
			assign tag_i  = tag_in;
			assign v_i    = in_valid;
		end else begin : g_body
			assign rad_i  = rad_s[i-1];
			assign rem_i  = rem_s[i-1];
			assign root_i = root_s[i-1];
			assign tag_i  = tag_s[i-1];
			assign v_i    = v_s[i-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign rem_sh = {rem_i[WIDTH-1:0], rad_i[2*WIDTH-1 -: 2]};
		assign trial  = {root_i, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i]  <= rad_i << 2;
				rem_s[i]  <= ge ? rem_sh - trial : rem_sh;
				root_s[i] <= {root_i[WIDTH-2:0], ge};
				tag_s[i]  <= tag_i;
			end
		end
	end

	assign out_valid = v_s[WIDTH-1];
	assign root      = root_s[WIDTH-1];
	assign tag_out   = tag_s[WIDTH-1];
endmodule
